[design/tkbs_pkg.sv]
package tkbs_pkg;

    // fixed field widths of the item and result ports
    localparam int SCORE_W    = 40;
    localparam int PORT_TAG_W = 16;
    localparam int COUNT_W    = 5;
    localparam int RANK_W     = 5;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [SCORE_W-1:0] t_score;

    // item sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_PUT,
        S_QRD,
        S_DONE
    } t_state;

endpackage

[design/tkbs_ram.sv]
module tkbs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/top_k_best_score_keeper.sv]
// Keeps the best entries seen so far (signed Q23.16 score plus tag) in a list memory sorted
// highest score first, at most capacity of them (capacity 0 acts as 1, above MAX_ENTRIES as
// MAX_ENTRIES; lowering it drops the lowest entries). An insert is kept while the list is not
// full, or when full only if its score is strictly above the lowest, which it then replaces;
// a new entry goes after older equal scores. A query returns the entry at a 1-based rank.
// Every item yields exactly one result, held in an output register so the next item can be
// taken while it waits; a result that cannot leave the output register holds the next one
// back. An insert moves each lower entry down one place, one entry per cycle from the bottom
// up through the one read and one write port of the list memory; when the list is full the
// lowest entry is compared first.
// The capacity register is written only while no item is offered or in work.
module top_k_best_score_keeper #(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tkbs_pkg::COUNT_W-1:0]       i_cfg_capacity,
    // item channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  tkbs_pkg::t_score                   i_score,
    input  logic [tkbs_pkg::PORT_TAG_W-1:0]    i_entry_tag,
    input  logic [tkbs_pkg::RANK_W-1:0]        i_rank,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_accepted,
    output logic                               o_found,
    output tkbs_pkg::t_score                   o_found_score,
    output logic [tkbs_pkg::PORT_TAG_W-1:0]    o_found_tag,
    output logic [tkbs_pkg::COUNT_W-1:0]       o_entry_count
);

    import tkbs_pkg::*;

    localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WORD_W = SCORE_W + TAG_BITS;
    localparam int CNT_MAX = 2**COUNT_W - 1;
    localparam logic [COUNT_W-1:0] CAP_LIM =
        COUNT_W'((MAX_ENTRIES < CNT_MAX) ? MAX_ENTRIES : CNT_MAX);

    // capacity in use for a register value
    function automatic logic [COUNT_W-1:0] f_cap(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] v;
        v = c;
        if (v == '0) v = COUNT_W'(1);
        if (v > CAP_LIM) v = CAP_LIM;
        return v;
    endfunction

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_cap;
    logic [COUNT_W-1:0]    r_held, n_held;
    logic [COUNT_W-1:0]    r_new_count, n_new_count;
    logic [COUNT_W-1:0]    w_cap, w_cfg_cap;
    logic [AW-1:0]         r_idx, n_idx;
    t_score                r_score;
    logic [TAG_BITS-1:0]   r_tag;
    logic                  r_res_accepted, n_res_accepted;
    logic                  r_res_found, n_res_found;
    logic                  w_in_fire, w_cfg_fire, w_load;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [WORD_W-1:0]     w_wdata, w_rdata;
    t_score                w_rd_score;
    logic [TAG_BITS-1:0]   w_rd_tag;

    logic                  r_out_valid;
    logic                  r_out_accepted, r_out_found;
    t_score                r_out_score;
    logic [PORT_TAG_W-1:0] r_out_tag;
    logic [COUNT_W-1:0]    r_out_count;

    // list memory, one word per entry
    tkbs_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (WORD_W),
        .AW    (AW)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_score = w_rdata[WORD_W-1 -: SCORE_W];
    assign w_rd_tag   = w_rdata[TAG_BITS-1:0];
    assign w_cap      = f_cap(r_cap);
    assign w_cfg_cap  = f_cap(i_cfg_capacity);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;

    // sequencer: scan from the bottom, shifting smaller entries down one place
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_res_accepted = r_res_accepted;
        n_res_found    = r_res_found;
        n_new_count    = r_new_count;
        w_we           = 1'b0;
        w_waddr        = r_idx + 1'b1;
        w_wdata        = {r_score, r_tag};
        w_re           = 1'b0;
        w_raddr        = r_idx - 1'b1;
        o_in_ready     = 1'b0;
        o_cfg_ready    = 1'b0;
        w_load         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cfg_ready = !i_in_valid;
                if (i_in_valid) begin
                    if (i_kind == KIND_QUERY) begin
                        n_new_count    = r_held;
                        n_res_accepted = 1'b0;
                        if (i_rank != '0 && i_rank <= r_held) begin
                            w_re        = 1'b1;
                            w_raddr     = AW'(i_rank - 1'b1);
                            n_res_found = 1'b1;
                            n_state     = S_QRD;
                        end else begin
                            n_res_found = 1'b0;
                            n_state     = S_DONE;
                        end
                    end else begin
                        n_res_found = 1'b0;
                        if (r_held < w_cap) begin
                            n_new_count    = r_held + 1'b1;
                            n_res_accepted = 1'b1;
                            if (r_held == '0) begin
                                n_state = S_PUT;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_held - 1'b1);
                                n_idx   = AW'(r_held - 1'b1);
                                n_state = S_SCAN;
                            end
                        end else begin
                            // full: look at the lowest entry first
                            n_new_count = r_held;
                            w_re        = 1'b1;
                            w_raddr     = AW'(w_cap - 1'b1);
                            n_idx       = AW'(w_cap - 1'b1);
                            n_state     = S_CHK;
                        end
                    end
                end
            end
            S_CHK: begin
                if (r_score > w_rd_score) begin
                    n_res_accepted = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        w_re    = 1'b1;
                        n_idx   = r_idx - 1'b1;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_res_accepted = 1'b0;
                    n_state        = S_DONE;
                end
            end
            S_SCAN: begin
                w_we = 1'b1;
                if (w_rd_score >= r_score) begin
                    // new entry sits just below this one
                    n_state = S_DONE;
                end else begin
                    w_wdata = w_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        w_re    = 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                n_state = S_DONE;
            end
            S_QRD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry count, clipped when the capacity is lowered
    always_comb begin
        n_held = w_load ? r_new_count : r_held;
        if (w_cfg_fire && n_held > w_cfg_cap) begin
            n_held = w_cfg_cap;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            if (w_cfg_fire) begin
                r_cap <= i_cfg_capacity;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_idx          <= n_idx;
        r_res_accepted <= n_res_accepted;
        r_res_found    <= n_res_found;
        r_new_count    <= n_new_count;
        if (w_in_fire) begin
            r_score <= i_score;
            r_tag   <= TAG_BITS'(i_entry_tag);
        end
        if (w_load) begin
            r_out_accepted <= r_res_accepted;
            r_out_found    <= r_res_found;
            r_out_score    <= r_res_found ? w_rd_score : '0;
            r_out_tag      <= r_res_found ? PORT_TAG_W'(w_rd_tag) : '0;
            r_out_count    <= r_new_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_accepted;
    assign o_found       = r_out_found;
    assign o_found_score = r_out_score;
    assign o_found_tag   = r_out_tag;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    // entries held never exceed the capacity in use
    a_held_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= w_cap)
        else $error("held count above capacity");

    // a shift step never reads the entry it writes
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("read and write to the same entry");

    // the scan only visits held entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CHK) |->
        ({{COUNT_W{1'b0}}, r_idx} < {{AW{1'b0}}, r_held}))
        else $error("scan index beyond held entries");

    // count grows by one only for a kept insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> ((r_new_count == r_held) ||
                    (r_new_count == r_held + 1'b1 && r_res_accepted)))
        else $error("entry count step wrong");
`endif

endmodule
